// ----- rtl/nsf_pkg.sv -----
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int MAX_LINE_DEF = 128;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_BAD  = 2'd1,
        EV_GOOD = 2'd2
    } ev_t;

    typedef struct packed {
        ev_t         ev;
        logic [6:0]  plen;
        logic [7:0]  pcs;
        logic [31:0] bad;
        logic [31:0] trunc;
        logic [31:0] over;
    } res_t;

    // {valid, value} of one hex digit, upper or lower case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
        begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
        begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/nsf_line.sv -----
`timescale 1ns / 1ps

module nsf_line #(
    parameter int MAX_LINE = nsf_pkg::MAX_LINE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     rx_byte,
    output nsf_pkg::res_t  res
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic             in_sent_reg, in_sent_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       r0_reg, r0_next;
    logic [7:0]       r1_reg, r1_next;
    logic [7:0]       r2_reg, r2_next;
    logic [31:0]      bad_reg, bad_next;
    logic [31:0]      trunc_reg, trunc_next;
    logic [31:0]      over_reg, over_next;

    logic [4:0]       hi_dig;
    logic [4:0]       lo_dig;
    logic [7:0]       got;
    logic [LEN_W-1:0] plen_full;

    assign hi_dig    = nsf_pkg::hex_decode(r1_reg);
    assign lo_dig    = nsf_pkg::hex_decode(r0_reg);
    assign got       = xor_reg ^ r0_reg ^ r1_reg ^ r2_reg;
    assign plen_full = len_reg - LEN_W'(4);

    always_comb
    begin
        in_sent_next = in_sent_reg;
        len_next     = len_reg;
        xor_next     = xor_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        bad_next     = bad_reg;
        trunc_next   = trunc_reg;
        over_next    = over_reg;
        res.ev       = nsf_pkg::EV_NONE;
        res.plen     = 7'd0;
        res.pcs      = 8'd0;
        if (step)
        begin
            if (rx_byte == nsf_pkg::CH_START)
            begin
                if (in_sent_reg && len_reg > LEN_W'(1))
                begin
                    trunc_next = trunc_reg + 32'd1;
                end
                in_sent_next = 1'b1;
                len_next     = LEN_W'(1);
                xor_next     = 8'd0;
                r0_next      = 8'd0;
                r1_next      = 8'd0;
                r2_next      = 8'd0;
            end
            else if (in_sent_reg)
            begin
                priority if (rx_byte == nsf_pkg::CH_CR || rx_byte == nsf_pkg::CH_LF)
                begin
                    if (len_reg > LEN_W'(1))
                    begin
                        if (len_reg < LEN_W'(5) || r2_reg != nsf_pkg::CH_STAR ||
                            !hi_dig[4] || !lo_dig[4] || got != {hi_dig[3:0], lo_dig[3:0]})
                        begin
                            bad_next = bad_reg + 32'd1;
                            res.ev   = nsf_pkg::EV_BAD;
                        end
                        else
                        begin
                            res.ev   = nsf_pkg::EV_GOOD;
                            res.plen = 7'(plen_full);
                            res.pcs  = got;
                        end
                    end
                    in_sent_next = 1'b0;
                    len_next     = '0;
                    xor_next     = 8'd0;
                    r0_next      = 8'd0;
                    r1_next      = 8'd0;
                    r2_next      = 8'd0;
                end
                else if (len_reg >= LEN_W'(MAX_LINE))
                begin
                    // drop overlong line
                    over_next    = over_reg + 32'd1;
                    res.ev       = nsf_pkg::EV_BAD;
                    in_sent_next = 1'b0;
                    len_next     = '0;
                    xor_next     = 8'd0;
                    r0_next      = 8'd0;
                    r1_next      = 8'd0;
                    r2_next      = 8'd0;
                end
                else
                begin
                    xor_next = xor_reg ^ rx_byte;
                    r2_next  = r1_reg;
                    r1_next  = r0_reg;
                    r0_next  = rx_byte;
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
        res.bad   = bad_next;
        res.trunc = trunc_next;
        res.over  = over_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg <= 1'b0;
            len_reg     <= '0;
            xor_reg     <= 8'd0;
            r0_reg      <= 8'd0;
            r1_reg      <= 8'd0;
            r2_reg      <= 8'd0;
            bad_reg     <= 32'd0;
            trunc_reg   <= 32'd0;
            over_reg    <= 32'd0;
        end
        else
        begin
            in_sent_reg <= in_sent_next;
            len_reg     <= len_next;
            xor_reg     <= xor_next;
            r0_reg      <= r0_next;
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            bad_reg     <= bad_next;
            trunc_reg   <= trunc_next;
            over_reg    <= over_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LINE))
        else $error("line length beyond limit");

    a_closed_len: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sent_reg |-> len_reg == '0 && xor_reg == 8'd0)
        else $error("closed line holds state");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_sent_reg && rx_byte != nsf_pkg::CH_START |-> res.ev == nsf_pkg::EV_NONE)
        else $error("event outside a line");

    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.ev == nsf_pkg::EV_GOOD |-> len_reg >= LEN_W'(5))
        else $error("valid sentence too short");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(len_reg) && $stable(bad_reg) && $stable(over_reg))
        else $error("state moved without a word");

endmodule

// ----- rtl/nmea_sentence_framer_unit.sv -----
`timescale 1ns / 1ps

// NMEA 0183 sentence framer: takes one received byte per word and returns one
// result word per byte, carrying the line event (none, bad, valid sentence),
// the payload length and checksum of a valid sentence, and the three wrapping
// counters for bad, truncated and overlong lines. A new byte is taken every
// cycle while the output is not stalled; each byte passes an input register
// and then the result register, which holds its result. Lines longer than
// MAX_LINE characters are dropped as overlong.
module nmea_sentence_framer_unit #(
    parameter int MAX_LINE = nsf_pkg::MAX_LINE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  event_res,
    output logic [6:0]  payload_length,
    output logic [7:0]  payload_checksum,
    output logic [31:0] bad_count,
    output logic [31:0] truncated_count,
    output logic [31:0] overlong_count
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          out_valid_reg;
    nsf_pkg::res_t out_reg;
    nsf_pkg::res_t res;
    logic          advance;
    logic          accept;

    assign advance  = s1_valid_reg && (!out_valid_reg || !res_stall);
    assign rx_stall = s1_valid_reg && !advance;
    assign accept   = rx_valid && !rx_stall;

    nsf_line #(
        .MAX_LINE (MAX_LINE)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (s1_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign res_valid        = out_valid_reg;
    assign event_res        = out_reg.ev;
    assign payload_length   = out_reg.plen;
    assign payload_checksum = out_reg.pcs;
    assign bad_count        = out_reg.bad;
    assign truncated_count  = out_reg.trunc;
    assign overlong_count   = out_reg.over;

endmodule
